// ----- src/ima4_pkg.sv -----
// ----------------------------------------------------------------------------
// ima4_pkg
// Shared types, constants and tables for the IMA4 ADPCM packet decoder.
// ----------------------------------------------------------------------------
package ima4_pkg;

    // packet layout
    localparam int DATA_BYTES = 32;
    localparam int BPOS_W     = $clog2(DATA_BYTES + 2);
    localparam int DIDX_W     = 5;

    // queue sizes
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;

    // configuration register map
    localparam int          ADDR_W          = 3;
    localparam logic [0:0]  REG_STEREO_MODE = 1'b0;

    // step index limits
    localparam logic [6:0] STEP_IDX_MAX = 7'd88;

    typedef enum logic [0:0] {
        CMD_INIT = 1'b0,
        CMD_DATA = 1'b1
    } cmd_kind_t;

    // request passed from front end to decode back end
    typedef struct packed {
        cmd_kind_t          kind;
        logic [15:0]        hdr;
        logic               chan;
        logic [DIDX_W-1:0]  didx;
        logic               last;
    } cmd_t;

    // one decoded result
    typedef struct packed {
        logic signed [15:0] sample;
        logic               channel;
        logic [5:0]         sample_index;
        logic               last_of_byte;
        logic               end_of_packet;
    } res_t;

    localparam logic [14:0] STEP_TAB [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
        15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
        15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
        15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
        15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
        15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
        15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
        15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
        15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
        15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
        15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // step size for a step index, indexes above the top read the last entry
    function automatic logic [14:0] step_lookup(input logic [6:0] idx);
        logic [14:0] val;
        if (idx > STEP_IDX_MAX)
            val = STEP_TAB[STEP_IDX_MAX];
        else
            val = STEP_TAB[idx];
        return val;
    endfunction

    // step index adjustment from the magnitude bits of a nibble
    function automatic logic signed [4:0] idx_adj(input logic [2:0] mag);
        logic signed [4:0] val;
        unique case (mag)
            3'd4:    val = 5'sd2;
            3'd5:    val = 5'sd4;
            3'd6:    val = 5'sd6;
            3'd7:    val = 5'sd8;
            default: val = -5'sd1;
        endcase
        return val;
    endfunction

    // clamp a header step index to the table range
    function automatic logic [6:0] clamp_hdr_idx(input logic [6:0] idx);
        return (idx > STEP_IDX_MAX) ? STEP_IDX_MAX : idx;
    endfunction

endpackage

// ----- src/ima4_front.sv -----
// ----------------------------------------------------------------------------
// ima4_front
// Byte front end: tracks packet position and channel, turns header and data
// bytes into decode requests.
// ----------------------------------------------------------------------------
module ima4_front
    import ima4_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  stereo_mode,
    input  logic  push,
    input  logic  [7:0] byte_in,
    input  logic  cmdq_full,
    output logic  full,
    output logic  cmd_push,
    output cmd_t  cmd
);

    logic [BPOS_W-1:0] bpos_reg, bpos_next;
    logic [7:0]        hdr_hi_reg, hdr_hi_next;
    logic              chan_reg, chan_next;
    logic [BPOS_W-1:0] data_off;
    logic              accept;
    logic              last;

    assign full     = cmdq_full;
    assign accept   = push && !cmdq_full;
    assign data_off = bpos_reg - BPOS_W'(2);
    assign last     = (bpos_reg == BPOS_W'(DATA_BYTES + 1));

    // request built from the current byte
    always_comb
    begin
        cmd.kind = (bpos_reg == BPOS_W'(1)) ? CMD_INIT : CMD_DATA;
        cmd.hdr  = {hdr_hi_reg, byte_in};
        cmd.chan = chan_reg & stereo_mode;
        cmd.didx = data_off[DIDX_W-1:0];
        cmd.last = last;
    end

    // the first header byte is only held, every later byte makes a request
    assign cmd_push = accept && (bpos_reg != '0);

    // packet position and channel tracking
    always_comb
    begin
        bpos_next   = bpos_reg;
        hdr_hi_next = hdr_hi_reg;
        chan_next   = chan_reg;
        if (accept)
        begin
            if (bpos_reg == '0)
            begin
                hdr_hi_next = byte_in;
                bpos_next   = BPOS_W'(1);
            end
            else if (bpos_reg == BPOS_W'(1))
            begin
                bpos_next = BPOS_W'(2);
            end
            else if (last)
            begin
                bpos_next = '0;
                chan_next = stereo_mode ? !chan_reg : 1'b0;
            end
            else
            begin
                bpos_next = bpos_reg + BPOS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpos_reg   <= '0;
            hdr_hi_reg <= '0;
            chan_reg   <= 1'b0;
        end
        else
        begin
            bpos_reg   <= bpos_next;
            hdr_hi_reg <= hdr_hi_next;
            chan_reg   <= chan_next;
        end
    end

endmodule

// ----- src/ima4_cmdq.sv -----
// ----------------------------------------------------------------------------
// ima4_cmdq
// Short show-ahead queue of decode requests between front end and back end.
// ----------------------------------------------------------------------------
module ima4_cmdq
    import ima4_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  cmd_t  wr_data,
    output logic  full,
    input  logic  rd_en,
    output cmd_t  rd_data,
    output logic  valid
);

    cmd_t                 mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_AW:0]     count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full    = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (CMDQ_AW+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (CMDQ_AW+1)'(1);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + CMDQ_AW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + CMDQ_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/ima4_back.sv -----
// ----------------------------------------------------------------------------
// ima4_back
// Decode back end: loads predictor and step index from header requests and
// decodes one nibble per cycle into a small result queue while it has room.
// ----------------------------------------------------------------------------
module ima4_back
    import ima4_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    input  cmd_t  cmd,
    output logic  cmd_pop,
    input  logic  pop,
    output logic  empty,
    output res_t  res
);

    logic signed [15:0]   pred_reg, pred_next;
    logic [6:0]           sidx_reg, sidx_next;
    logic                 phase_reg, phase_next;

    res_t                 outq_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [OUTQ_AW:0]     count_reg, count_next;
    logic                 outq_full;
    logic                 do_pop;

    logic                 do_init, do_data;
    logic [3:0]           nib;
    logic [14:0]          step;
    logic [16:0]          diff;
    logic signed [17:0]   psum;
    logic signed [15:0]   psat;
    logic signed [7:0]    idx_sum;
    logic [6:0]           idx_new;
    logic signed [15:0]   hdr_pred;
    res_t                 res_new;

    assign outq_full = (count_reg == (OUTQ_AW+1)'(OUTQ_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_pop    = pop && !empty;
    assign res       = outq_reg[rd_ptr_reg];

    // request scheduling
    assign do_init = cmd_valid && (cmd.kind == CMD_INIT);
    assign do_data = cmd_valid && (cmd.kind == CMD_DATA) && !outq_full;
    assign cmd_pop = do_init || (do_data && phase_reg);

    // nibble datapath
    always_comb
    begin
        nib  = phase_reg ? cmd.hdr[7:4] : cmd.hdr[3:0];
        step = step_lookup(sidx_reg);
        diff = 17'(step >> 3);
        if (nib[2])
            diff = diff + 17'(step);
        if (nib[1])
            diff = diff + 17'(step >> 1);
        if (nib[0])
            diff = diff + 17'(step >> 2);
        if (nib[3])
            psum = 18'(pred_reg) - $signed({1'b0, diff});
        else
            psum = 18'(pred_reg) + $signed({1'b0, diff});
        if (psum < -18'sd32768)
            psat = 16'sh8000;
        else if (psum > 18'sd32767)
            psat = 16'sh7fff;
        else
            psat = psum[15:0];
        idx_sum = $signed({1'b0, sidx_reg}) + 8'(idx_adj(nib[2:0]));
        if (idx_sum < 8'sd0)
            idx_new = 7'd0;
        else if (idx_sum > $signed({1'b0, STEP_IDX_MAX}))
            idx_new = STEP_IDX_MAX;
        else
            idx_new = idx_sum[6:0];
    end

    // header load value, top nine bits with low seven cleared
    assign hdr_pred = {cmd.hdr[15:7], 7'd0};

    // result entry
    always_comb
    begin
        res_new.sample        = psat;
        res_new.channel       = cmd.chan;
        res_new.sample_index  = {cmd.didx, phase_reg};
        res_new.last_of_byte  = phase_reg;
        res_new.end_of_packet = phase_reg && cmd.last;
    end

    // decoder state update
    always_comb
    begin
        pred_next  = pred_reg;
        sidx_next  = sidx_reg;
        phase_next = phase_reg;
        if (do_init)
        begin
            pred_next = hdr_pred;
            sidx_next = clamp_hdr_idx(cmd.hdr[6:0]);
        end
        else if (do_data)
        begin
            pred_next  = psat;
            sidx_next  = idx_new;
            phase_next = !phase_reg;
        end
    end

    // result queue occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_data && !do_pop)
            count_next = count_reg + (OUTQ_AW+1)'(1);
        else if (do_pop && !do_data)
            count_next = count_reg - (OUTQ_AW+1)'(1);
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (do_data)
            outq_reg[wr_ptr_reg] <= res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg   <= '0;
            sidx_reg   <= '0;
            phase_reg  <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            pred_reg  <= pred_next;
            sidx_reg  <= sidx_next;
            phase_reg <= phase_next;
            if (do_data)
                wr_ptr_reg <= wr_ptr_reg + OUTQ_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + OUTQ_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/ima4_adpcm_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// ima4_adpcm_packet_decoder
// IMA4 ADPCM packet decoder: one byte in per request, two 16-bit samples out
// per data byte, with channel tag and position within the packet.
// ----------------------------------------------------------------------------
// Path: a data byte's request is registered in the request queue and stays at
//   its head until both nibble samples are registered in the result queue.
// Throughput: one header byte per cycle while the request queue has room; the
//   datapath decodes one sample per cycle unless the result queue is full.
// Reset: rst_n clears position, predictor, step index, channel, queues and
//   stereo_mode at once; no clearing pass.
module ima4_adpcm_packet_decoder
    import ima4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // byte input
    input  logic                 push,
    input  logic [7:0]           byte_in,
    output logic                 full,
    // sample output
    output logic                 empty,
    input  logic                 pop,
    output logic signed [15:0]   sample,
    output logic                 channel,
    output logic [5:0]           sample_index,
    output logic                 last_of_byte,
    output logic                 end_of_packet
);

    logic   stereo_reg;
    logic   cfg_wr;
    logic   cmdq_full;
    logic   cmd_push;
    cmd_t   cmd_in;
    cmd_t   cmd_head;
    logic   cmd_valid;
    logic   cmd_pop;
    res_t   res;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_STEREO_MODE) ? {31'd0, stereo_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stereo_reg <= 1'b0;
        else if (cfg_wr && (paddr[2] == REG_STEREO_MODE))
            stereo_reg <= pwdata[0];
    end

    // front end
    ima4_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .stereo_mode (stereo_reg),
        .push        (push),
        .byte_in     (byte_in),
        .cmdq_full   (cmdq_full),
        .full        (full),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    // request queue
    ima4_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmdq_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .valid   (cmd_valid)
    );

    // decode back end
    ima4_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign sample        = res.sample;
    assign channel       = res.channel;
    assign sample_index  = res.sample_index;
    assign last_of_byte  = res.last_of_byte;
    assign end_of_packet = res.end_of_packet;

    // checks
    a_eop_on_high: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_packet) |-> last_of_byte)
        else $error("end of packet on a low-nibble sample");

    a_index_parity: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (sample_index[0] == last_of_byte))
        else $error("sample index parity does not match nibble");

    a_hdr_hi_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd_in.kind == CMD_INIT) |=> !(cmd_push && cmd_in.kind == CMD_INIT))
        else $error("two header requests in a row");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("request taken from an empty queue");

endmodule
